### src/iir4mc_pkg.sv
// ============================================================================
// iir4mc_pkg
// Shared widths, register indexes, history layout and the output rounding
// function of the fourth-order multichannel IIR filter.
// ============================================================================
package iir4mc_pkg;

    // field and datapath widths
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 5;
    localparam int FRAC_SHIFT  = 27;
    localparam int QUOT_W      = ACC_W - FRAC_SHIFT;
    localparam int TAPS        = 4;
    localparam int NUM_COEF    = 2 * TAPS + 1;
    localparam int PART_SUMS   = 3;
    localparam int PART_LEN    = NUM_COEF / PART_SUMS;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CHAN_W      = 1;
    localparam int DEF_CHANNELS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AB   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAST = 3'd4;

    // E = 1.0 in Q5.27, F = 0: input passes straight through
    localparam logic [CFG_DATA_W-1:0] EF_RESET = 64'h0800_0000_0000_0000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [QUOT_W-1:0]   quot_t;

    // one channel's history, index 0 newest
    typedef struct packed {
        sample_t [TAPS-1:0] y;
        sample_t [TAPS-1:0] u;
    } hist_t;

    localparam acc_t  ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);
    localparam quot_t SAT_MAX    = quot_t'(8388607);
    localparam quot_t SAT_MIN    = -quot_t'(8388608);

    // round half up from Q11.50 to Q1.23, then clamp to 24 bits
    function automatic sample_t round_sat(acc_t acc);
        acc_t    rnd;
        quot_t   q;
        sample_t r;
        rnd = acc + ROUND_HALF;
        q   = rnd[ACC_W-1:FRAC_SHIFT];
        if (q > SAT_MAX)
            r = SAT_MAX[SAMPLE_W-1:0];
        else if (q < SAT_MIN)
            r = SAT_MIN[SAMPLE_W-1:0];
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

### src/iir_fourth_order_multichannel_unit.sv
// ============================================================================
// iir_fourth_order_multichannel_unit
// Fourth-order direct form I IIR filter over interleaved channels, with the
// per-channel histories held in a synchronous memory.
// ============================================================================
// Usage
//   Input stream s_*: s_tdata carries the Q1.23 sample, s_tuser the channel.
//   Output stream m_*: the filtered, saturated Q1.23 sample and its channel,
//   one output request per input request, in input order. A request whose
//   channel is not below CHANNELS is taken and dropped without a result.
//   Coefficients are written through cfg_we / cfg_index / cfg_data while the
//   filter is idle; writes to unknown indexes are ignored.
// Pipeline and throughput
//   An accepted request passes history read, multiply, partial sums and
//   final sum with round/saturate before it shows up on m_tvalid.
//   One request per cycle while the output is not stalled and its channel
//   differs from those of the two requests before it. A channel's next
//   sample waits until its previous result is in the write-back stage, so
//   two alternating channels leave bubbles between their requests.
// Reset and stall
//   Reset clears every history (entry valid bits, no clearing pass), loads
//   the coefficient reset values and empties the pipeline. When m_tready is
//   low the output register holds; stages behind it keep filling bubbles
//   and s_tready drops when the pipeline is full or on a channel hazard.
// ============================================================================
module iir_fourth_order_multichannel_unit #(
    parameter int CHANNELS = iir4mc_pkg::DEF_CHANNELS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [iir4mc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iir4mc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [iir4mc_pkg::SAMPLE_W-1:0]      s_tdata,   // [23:0] sample_in
    input  logic [iir4mc_pkg::CHAN_W-1:0]        s_tuser,   // [0] chan
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [iir4mc_pkg::SAMPLE_W-1:0]      m_tdata,   // [23:0] sample_out
    output logic [iir4mc_pkg::CHAN_W-1:0]        m_tuser    // [0] chan_out
);
    import iir4mc_pkg::*;

    localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    typedef logic [ADDR_W-1:0] addr_t;

    // coefficient registers
    logic [CFG_DATA_W-1:0] coef_ab_reg;
    logic [CFG_DATA_W-1:0] coef_cd_reg;
    logic [CFG_DATA_W-1:0] coef_ef_reg;
    logic [CFG_DATA_W-1:0] coef_gh_reg;
    coef_t                 coef_last_reg;
    coef_t                 coef [NUM_COEF];

    // history memory and entry valid bits
    hist_t                 mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  ent_vld_reg;
    hist_t                 rd_data_reg;
    logic                  rd_vld_reg;
    logic                  fwd_reg;
    hist_t                 fwd_data_reg;

    // pipeline control
    logic                  s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic [CHAN_W-1:0]     s1_chan_reg, s2_chan_reg, s3_chan_reg, out_chan_reg;
    sample_t               s1_sample_reg, s2_sample_reg, s3_sample_reg;
    sample_t               out_sample_reg;
    hist_t                 s2_hist_reg, s3_hist_reg;
    prod_t                 s2_prod_reg [NUM_COEF];
    acc_t                  s3_psum_reg [PART_SUMS];

    logic                  adv0, adv1, adv2, adv3;
    logic                  hazard, in_range, accept;
    addr_t                 rd_addr, wr_addr;
    logic                  wr_en;
    hist_t                 wr_data;
    hist_t                 h1;
    sample_t               opnd [NUM_COEF];
    prod_t                 prod [NUM_COEF];
    acc_t                  psum [PART_SUMS];
    acc_t                  acc_sum;
    sample_t               res;

    // coefficient unpacking, A..I
    assign coef[0] = coef_ab_reg[63:32];
    assign coef[1] = coef_ab_reg[31:0];
    assign coef[2] = coef_cd_reg[63:32];
    assign coef[3] = coef_cd_reg[31:0];
    assign coef[4] = coef_ef_reg[63:32];
    assign coef[5] = coef_ef_reg[31:0];
    assign coef[6] = coef_gh_reg[63:32];
    assign coef[7] = coef_gh_reg[31:0];
    assign coef[8] = coef_last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_ab_reg   <= '0;
            coef_cd_reg   <= '0;
            coef_ef_reg   <= EF_RESET;
            coef_gh_reg   <= '0;
            coef_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AB:   coef_ab_reg   <= cfg_data;
                REG_CD:   coef_cd_reg   <= cfg_data;
                REG_EF:   coef_ef_reg   <= cfg_data;
                REG_GH:   coef_gh_reg   <= cfg_data;
                REG_LAST: coef_last_reg <= cfg_data[COEF_W-1:0];
                default:  ;
            endcase
        end
    end

    // stage advance chain, back to front
    assign adv3 = !out_v_reg || m_tready;
    assign adv2 = !s3_v_reg || adv3;
    assign adv1 = !s2_v_reg || adv2;
    assign adv0 = !s1_v_reg || adv1;

    // same-channel interlock; the write-back stage is forwarded
    assign hazard = (s1_v_reg && (s1_chan_reg == s_tuser))
                 || (s2_v_reg && (s2_chan_reg == s_tuser))
                 || (s3_v_reg && (s3_chan_reg == s_tuser) && !adv3);

    assign s_tready = adv0 && !hazard;
    assign in_range = 32'(s_tuser) < CHANNELS;
    assign accept   = s_tvalid && s_tready && in_range;
    assign rd_addr  = addr_t'(s_tuser);

    // history memory: one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (adv0)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
                ent_vld_reg[wr_addr] <= 1'b1;
            if (adv0)
            begin
                rd_vld_reg <= ent_vld_reg[rd_addr];
                fwd_reg    <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // stage 1: pick history, nine multiplies
    always_comb
    begin
        if (fwd_reg)
            h1 = fwd_data_reg;
        else if (rd_vld_reg)
            h1 = rd_data_reg;
        else
            h1 = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            opnd[i]            = h1.y[i];
            opnd[TAPS + 1 + i] = h1.u[i];
        end
        opnd[TAPS] = s1_sample_reg;
        for (int j = 0; j < NUM_COEF; j++)
            prod[j] = coef[j] * opnd[j];
    end

    // stage 2: three partial sums
    always_comb
    begin
        for (int p = 0; p < PART_SUMS; p++)
        begin
            psum[p] = '0;
            for (int k = 0; k < PART_LEN; k++)
                psum[p] = psum[p] + acc_t'(s2_prod_reg[p * PART_LEN + k]);
        end
    end

    // stage 3: final sum, round, saturate, history update
    always_comb
    begin
        acc_sum = s3_psum_reg[0] + s3_psum_reg[1] + s3_psum_reg[2];
        res     = round_sat(acc_sum);
        wr_data.y[0] = res;
        wr_data.u[0] = s3_sample_reg;
        for (int i = 1; i < TAPS; i++)
        begin
            wr_data.y[i] = s3_hist_reg.y[i - 1];
            wr_data.u[i] = s3_hist_reg.u[i - 1];
        end
    end

    assign wr_en   = s3_v_reg && adv3;
    assign wr_addr = addr_t'(s3_chan_reg);

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                s1_v_reg <= accept;
            if (adv1)
                s2_v_reg <= s1_v_reg;
            if (adv2)
                s3_v_reg <= s2_v_reg;
            if (adv3)
                out_v_reg <= s3_v_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            s1_chan_reg   <= s_tuser;
            s1_sample_reg <= s_tdata;
        end
        if (adv1)
        begin
            s2_chan_reg   <= s1_chan_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_hist_reg   <= h1;
            for (int j = 0; j < NUM_COEF; j++)
                s2_prod_reg[j] <= prod[j];
        end
        if (adv2)
        begin
            s3_chan_reg   <= s2_chan_reg;
            s3_sample_reg <= s2_sample_reg;
            s3_hist_reg   <= s2_hist_reg;
            for (int p = 0; p < PART_SUMS; p++)
                s3_psum_reg[p] <= psum[p];
        end
        if (adv3)
        begin
            out_chan_reg   <= s3_chan_reg;
            out_sample_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_chan_reg;

    // a sample never enters while the same channel waits in stage 1 or 2
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |->
            !((s1_v_reg && s1_chan_reg == s_tuser) || (s2_v_reg && s2_chan_reg == s_tuser)))
        else $error("same-channel request accepted while history update pending");

    // only channels below CHANNELS ever reach the pipeline
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> (32'(s1_chan_reg) < CHANNELS))
        else $error("out-of-range channel entered the pipeline");

    // a new result always comes from the write-back stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(s3_v_reg))
        else $error("output valid without a result in the last stage");

    // a write-back marks its history entry as written
    a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> ent_vld_reg[$past(wr_addr)])
        else $error("history entry not marked after write-back");

endmodule
